### src/ile_pkg.sv
// Shared types and codes for the indexed list engine.
// Used by the controller, the datapath and the top level; no dependencies.
package ile_pkg;

    localparam logic [2:0] KIND_GET      = 3'd0;
    localparam logic [2:0] KIND_ADD_HEAD = 3'd1;
    localparam logic [2:0] KIND_ADD_TAIL = 3'd2;
    localparam logic [2:0] KIND_ADD_AT   = 3'd3;
    localparam logic [2:0] KIND_DELETE   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [31:0] READ_FAIL = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WALK_START,
        OP_WALK,
        OP_READ_ELEM,
        OP_ALLOC,
        OP_POP_FREE,
        OP_LINK_NEW,
        OP_LINK_PREV,
        OP_DEL_READ,
        OP_DEL_HEAD,
        OP_DEL_VICTIM,
        OP_DEL_BYPASS,
        OP_DEL_FREE,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        CLS_GET,
        CLS_INS,
        CLS_DEL,
        CLS_FAIL
    } cls_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic at_head;
        logic walk_needed;
        logic walk_last;
    } dp_status_t;

endpackage

### src/indexed_list_engine_core.sv
// Indexed list engine: ordered list of signed 32-bit values kept as a linked
// list in on-chip RAM. Top level; depends on ile_pkg, ile_controller, ile_datapath.
//
// A request is taken when start is high and busy is low; busy stays high
// until the result beat, which sits on status, read_value and count_after for
// the single cycle that done is high and cannot be held off. A request that
// needs no list access (out of range, full store, unknown kind) goes from
// decode straight to the done beat. Otherwise the link store is read once per
// list step. A new request may be presented in the same cycle as the done
// beat. No clearing pass is needed after reset.
module indexed_list_engine_core #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic signed [15:0]            position,
    input  logic signed [31:0]            item_value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic signed [31:0]            read_value,
    output logic [$clog2(CAPACITY+1)-1:0] count_after
);

    import ile_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    cmd_t       cmd;
    dp_status_t stat;

    ile_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ile_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .position    (position),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .count_after (count_after)
    );

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not raise busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_after <= CW'(CAPACITY)))
        else $error("count beyond capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count_after == CW'(CAPACITY)))
        else $error("full status with room left");
`endif

endmodule

### src/ile_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/ile_controller.sv
// Sequencer for the indexed list engine: steps each request through decode,
// link walk and store updates. Depends on ile_pkg.
module ile_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ile_pkg::dp_status_t stat,
    output ile_pkg::cmd_t       cmd,
    output logic                busy
);

    import ile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK_GO,
        S_WALK,
        S_GET_RD,
        S_ALLOC,
        S_POP,
        S_LINK_NEW,
        S_LINK_PREV,
        S_DEL_RD,
        S_DEL_HEAD,
        S_DEL_VICT,
        S_DEL_BYPASS,
        S_DEL_FREE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    state_t dispatch;

    always_comb
    begin
        case (stat.cls)
            CLS_GET: dispatch = S_GET_RD;
            CLS_INS: dispatch = S_ALLOC;
            CLS_DEL: dispatch = S_DEL_RD;
            default: dispatch = S_FINISH;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.cls == CLS_FAIL)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.walk_needed)
                begin
                    state_next = S_WALK_GO;
                end
                else
                begin
                    state_next = dispatch;
                end
            end
            S_WALK_GO:
            begin
                cmd.op     = OP_WALK_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (stat.walk_last)
                begin
                    state_next = dispatch;
                end
            end
            S_GET_RD:
            begin
                cmd.op     = OP_READ_ELEM;
                state_next = S_FINISH;
            end
            S_ALLOC:
            begin
                cmd.op     = OP_ALLOC;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.op     = OP_POP_FREE;
                state_next = S_LINK_NEW;
            end
            S_LINK_NEW:
            begin
                cmd.op     = OP_LINK_NEW;
                state_next = stat.at_head ? S_FINISH : S_LINK_PREV;
            end
            S_LINK_PREV:
            begin
                cmd.op     = OP_LINK_PREV;
                state_next = S_FINISH;
            end
            S_DEL_RD:
            begin
                cmd.op     = OP_DEL_READ;
                state_next = stat.at_head ? S_DEL_HEAD : S_DEL_VICT;
            end
            S_DEL_HEAD:
            begin
                cmd.op     = OP_DEL_HEAD;
                state_next = S_DEL_FREE;
            end
            S_DEL_VICT:
            begin
                cmd.op     = OP_DEL_VICTIM;
                state_next = S_DEL_BYPASS;
            end
            S_DEL_BYPASS:
            begin
                cmd.op     = OP_DEL_BYPASS;
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                cmd.op     = OP_DEL_FREE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### src/ile_datapath.sv
// Datapath of the indexed list engine: element and link stores, list and
// free-chain pointers, count and result registers. Depends on ile_pkg, ile_ram.
module ile_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ile_pkg::cmd_t                 cmd,
    output ile_pkg::dp_status_t           stat,
    input  logic [2:0]                    kind,
    input  logic signed [15:0]            position,
    input  logic signed [31:0]            item_value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic signed [31:0]            read_value,
    output logic [$clog2(CAPACITY+1)-1:0] count_after
);

    import ile_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 15) ? CW : 15) + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] wm_reg, wm_next;
    logic [CW-1:0] count_reg, count_next;
    cls_t          cls_reg, cls_next;
    logic          done_reg, done_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [1:0]    code_reg, code_next;
    logic          at_head_reg, at_head_next;
    logic          get_reg, get_next;
    logic [31:0]   value_reg, value_next;
    logic          took_free_reg, took_free_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   read_value_reg, read_value_next;
    logic [CW-1:0] count_after_reg, count_after_next;

    logic          link_we, link_re, elem_we, elem_re;
    logic [AW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic [AW-1:0] elem_waddr, elem_raddr;
    logic [31:0]   elem_rdata;

    logic [CMPW-1:0] pos_ext, cnt_ext, k_ext;
    logic            pos_neg, in_range, full;
    cls_t            dec_cls;
    logic [1:0]      dec_code;
    logic            dec_at_head;
    logic [CW-1:0]   dec_steps;

    ile_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ile_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (value_reg),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    // request decode
    always_comb
    begin
        pos_neg     = position[15];
        pos_ext     = CMPW'(position[14:0]);
        cnt_ext     = CMPW'(count_reg);
        in_range    = !pos_neg && (pos_ext < cnt_ext);
        full        = (count_reg == CW'(CAPACITY));
        k_ext       = pos_neg ? '0 : pos_ext;
        dec_cls     = CLS_FAIL;
        dec_code    = ST_RANGE;
        dec_at_head = 1'b0;
        dec_steps   = '0;
        case (kind)
            KIND_GET:
            begin
                if (in_range)
                begin
                    dec_cls   = CLS_GET;
                    dec_code  = ST_DONE;
                    dec_steps = CW'(pos_ext);
                end
            end
            KIND_ADD_HEAD:
            begin
                dec_at_head = 1'b1;
                if (full)
                begin
                    dec_code = ST_FULL;
                end
                else
                begin
                    dec_cls  = CLS_INS;
                    dec_code = ST_DONE;
                end
            end
            KIND_ADD_TAIL:
            begin
                dec_at_head = (count_reg == '0);
                dec_steps   = count_reg - CW'(1);
                if (full)
                begin
                    dec_code = ST_FULL;
                end
                else
                begin
                    dec_cls  = CLS_INS;
                    dec_code = ST_DONE;
                end
            end
            KIND_ADD_AT:
            begin
                dec_at_head = (k_ext == '0);
                dec_steps   = CW'(k_ext - CMPW'(1));
                if (k_ext > cnt_ext)
                begin
                    dec_code = ST_RANGE;
                end
                else if (full)
                begin
                    dec_code = ST_FULL;
                end
                else
                begin
                    dec_cls  = CLS_INS;
                    dec_code = ST_DONE;
                end
            end
            KIND_DELETE:
            begin
                dec_at_head = (pos_ext == '0);
                dec_steps   = CW'(pos_ext - CMPW'(1));
                if (in_range)
                begin
                    dec_cls  = CLS_DEL;
                    dec_code = ST_DONE;
                end
            end
            default:
            begin
                dec_cls  = CLS_FAIL;
                dec_code = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        head_next        = head_reg;
        free_head_next   = free_head_reg;
        free_cnt_next    = free_cnt_reg;
        wm_next          = wm_reg;
        count_next       = count_reg;
        cls_next         = cls_reg;
        done_next        = 1'b0;
        cur_next         = cur_reg;
        slot_next        = slot_reg;
        steps_next       = steps_reg;
        code_next        = code_reg;
        at_head_next     = at_head_reg;
        get_next         = get_reg;
        value_next       = value_reg;
        took_free_next   = took_free_reg;
        status_next      = status_reg;
        read_value_next  = read_value_reg;
        count_after_next = count_after_reg;
        link_we          = 1'b0;
        link_waddr       = cur_reg;
        link_wdata       = slot_reg;
        link_re          = 1'b0;
        link_raddr       = cur_reg;
        elem_we          = 1'b0;
        elem_waddr       = slot_reg;
        elem_re          = 1'b0;
        elem_raddr       = cur_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                cls_next     = dec_cls;
                code_next    = dec_code;
                at_head_next = dec_at_head;
                steps_next   = dec_steps;
                get_next     = (kind == KIND_GET);
                value_next   = item_value;
                cur_next     = head_reg;
            end
            OP_WALK_START:
            begin
                link_re    = 1'b1;
                link_raddr = cur_reg;
            end
            OP_WALK:
            begin
                cur_next   = link_rdata;
                steps_next = steps_reg - CW'(1);
                link_re    = 1'b1;
                link_raddr = link_rdata;
            end
            OP_READ_ELEM:
            begin
                elem_re    = 1'b1;
                elem_raddr = cur_reg;
            end
            OP_ALLOC:
            begin
                if (free_cnt_reg != '0)
                begin
                    slot_next      = free_head_reg;
                    elem_waddr     = free_head_reg;
                    link_re        = 1'b1;
                    link_raddr     = free_head_reg;
                    took_free_next = 1'b1;
                end
                else
                begin
                    slot_next      = wm_reg[AW-1:0];
                    elem_waddr     = wm_reg[AW-1:0];
                    wm_next        = wm_reg + CW'(1);
                    took_free_next = 1'b0;
                end
                elem_we = 1'b1;
            end
            OP_POP_FREE:
            begin
                if (took_free_reg)
                begin
                    free_head_next = link_rdata;
                    free_cnt_next  = free_cnt_reg - CW'(1);
                end
                link_re    = 1'b1;
                link_raddr = cur_reg;
            end
            OP_LINK_NEW:
            begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = at_head_reg ? head_reg : link_rdata;
                if (at_head_reg)
                begin
                    head_next = slot_reg;
                end
            end
            OP_LINK_PREV:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
            end
            OP_DEL_READ:
            begin
                link_re    = 1'b1;
                link_raddr = cur_reg;
                slot_next  = cur_reg;
            end
            OP_DEL_HEAD:
            begin
                head_next = link_rdata;
            end
            OP_DEL_VICTIM:
            begin
                slot_next  = link_rdata;
                link_re    = 1'b1;
                link_raddr = link_rdata;
            end
            OP_DEL_BYPASS:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_rdata;
            end
            OP_DEL_FREE:
            begin
                link_we        = 1'b1;
                link_waddr     = slot_reg;
                link_wdata     = free_head_reg;
                free_head_next = slot_reg;
                free_cnt_next  = free_cnt_reg + CW'(1);
            end
            OP_FINISH:
            begin
                if (cls_reg == CLS_INS)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if (cls_reg == CLS_DEL)
                begin
                    count_next = count_reg - CW'(1);
                end
                done_next   = 1'b1;
                status_next = code_reg;
                if (cls_reg == CLS_GET)
                begin
                    read_value_next = elem_rdata;
                end
                else if (get_reg)
                begin
                    read_value_next = READ_FAIL;
                end
                else
                begin
                    read_value_next = '0;
                end
                count_after_next = count_next;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            free_head_reg <= '0;
            free_cnt_reg  <= '0;
            wm_reg        <= '0;
            count_reg     <= '0;
            cls_reg       <= CLS_FAIL;
            done_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            wm_reg        <= wm_next;
            count_reg     <= count_next;
            cls_reg       <= cls_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        slot_reg        <= slot_next;
        steps_reg       <= steps_next;
        code_reg        <= code_next;
        at_head_reg     <= at_head_next;
        get_reg         <= get_next;
        value_reg       <= value_next;
        took_free_reg   <= took_free_next;
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        count_after_reg <= count_after_next;
    end

    assign stat.cls         = cls_reg;
    assign stat.at_head     = at_head_reg;
    assign stat.walk_needed = !at_head_reg && (steps_reg != '0);
    assign stat.walk_last   = (steps_reg == CW'(1));

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign count_after = count_after_reg;

endmodule
